/* rtl/sdtq_pkg.sv */
// Shared types and codes of the sorted deadline timer queue.
package sdtq_pkg;

  localparam int TW  = 64;  // deadline and tick counter width
  localparam int IW  = 32;  // timer id and tag width
  localparam int PCW = 5;   // reported pending count width
  localparam int MAX_RESULTS = 16;
  localparam int TNW = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_SET       = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;
  localparam logic [1:0] OP_CLEAR_ALL = 2'd3;

  localparam logic [2:0] KIND_SET       = 3'd0;
  localparam logic [2:0] KIND_CLEAR     = 3'd1;
  localparam logic [2:0] KIND_CLEAR_ALL = 3'd2;
  localparam logic [2:0] KIND_EXPIRY    = 3'd3;
  localparam logic [2:0] KIND_TICK_IDLE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [TW-1:0] deadline;
    logic [IW-1:0] id;
    logic [IW-1:0] tag;
  } sdtq_entry_t;

  typedef struct packed {
    logic [2:0]     kind;
    logic [1:0]     status;
    logic [IW-1:0]  timer_id;
    logic [IW-1:0]  tag;
    logic [PCW-1:0] pending;
    logic           last;
  } sdtq_result_t;

endpackage

/* rtl/sdtq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sdtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/sdtq_out_reg.sv */
// Result output register: holds one beat until the sink takes it.
module sdtq_out_reg import sdtq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  sdtq_result_t push_beat,
  output logic         free,
  output logic         out_valid,
  input  logic         out_stall,
  output sdtq_result_t beat
);

  logic valid_r, valid_nxt;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      beat <= push_beat;
    end
  end

endmodule

/* rtl/sorted_deadline_timer_queue.sv */
// Sorted deadline timer queue: top level, sequencer and entry memory.
//
//  channel  dir  handshake            beat contents
//  -------  ---  -------------------  -------------------------------------------
//  in_      in   in_valid/in_stall    opcode, delay_ticks, payload_tag, target_id
//  out_     out  out_valid/out_stall  result_kind, status, timer_id, expired_tag,
//                                     pending_count, last_result
//
// One input beat is worked on at a time; in_stall is low only when the sequencer is idle.
// Set: a shift walk from the tail moves each entry with a later or equal deadline up one slot.
// Clear: a search and close-up walk over the stored entries.
// Tick: expired entries are taken off the head in turn; clear-all and a refused set go straight
// to the reply. Each walk step is one access on the single read port of the entry memory.
// Synchronous active-low reset empties the queue at once: no clearing pass.
// A stalled output register holds the sequencer in place; no beat is dropped.
module sorted_deadline_timer_queue import sdtq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_opcode,
  input  logic [31:0]     in_delay_ticks,
  input  logic [31:0]     in_payload_tag,
  input  logic [31:0]     in_target_id,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      out_result_kind,
  output logic [1:0]      out_status,
  output logic [31:0]     out_timer_id,
  output logic [31:0]     out_expired_tag,
  output logic [PCW-1:0]  out_pending_count,
  output logic            out_last_result
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SET_ADD  = 3'd1;
  localparam logic [2:0] S_SET_WALK = 3'd2;
  localparam logic [2:0] S_SET_PUT  = 3'd3;
  localparam logic [2:0] S_CLR_WALK = 3'd4;
  localparam logic [2:0] S_TICK_CHK = 3'd5;
  localparam logic [2:0] S_REPLY    = 3'd6;

  // Entries live in a circular buffer; logical slot 0 is the head (earliest deadline).
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]    state_r, state_nxt;
  logic [TW-1:0] now_r, now_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [IW-1:0] next_id_r, next_id_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] delay_r, delay_nxt;
  logic [IW-1:0] tag_r, tag_nxt;
  logic [IW-1:0] target_r, target_nxt;
  logic [TW-1:0] dl_r, dl_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic [2:0]    rep_kind_r, rep_kind_nxt;
  logic [1:0]    rep_status_r, rep_status_nxt;
  logic [IW-1:0] rep_id_r, rep_id_nxt;
  logic [TNW-1:0] tick_n_r, tick_n_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [IW-1:0] pend_id_r, pend_id_nxt;
  logic [IW-1:0] pend_tag_r, pend_tag_nxt;
  logic [CW-1:0] pend_cnt_r, pend_cnt_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  sdtq_entry_t   ram_wdata, ram_rdata, new_entry;

  logic          push, free, in_accept, expire, match;
  sdtq_result_t  push_beat, beat;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign new_entry = '{deadline: dl_r, id: id_r, tag: tag_r};
  assign expire    = (cnt_r != '0) && (ram_rdata.deadline <= now_r)
                     && (tick_n_r < TNW'(MAX_RESULTS));
  assign match     = !found_r && (ram_rdata.id == target_r);

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    next_id_nxt    = next_id_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    delay_nxt      = delay_r;
    tag_nxt        = tag_r;
    target_nxt     = target_r;
    dl_nxt         = dl_r;
    id_nxt         = id_r;
    rep_kind_nxt   = rep_kind_r;
    rep_status_nxt = rep_status_r;
    rep_id_nxt     = rep_id_r;
    tick_n_nxt     = tick_n_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    pend_tag_nxt   = pend_tag_r;
    pend_cnt_nxt   = pend_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = head_r;
    ram_wdata      = new_entry;
    ram_re         = 1'b0;
    ram_raddr      = head_r;
    push           = 1'b0;
    push_beat      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          delay_nxt  = in_delay_ticks;
          tag_nxt    = in_payload_tag;
          target_nxt = in_target_id;
          unique case (in_opcode)
            OP_SET: begin
              if (cnt_r >= DEPTH_C) begin
                rep_kind_nxt   = KIND_SET;
                rep_status_nxt = ST_FULL;
                rep_id_nxt     = '0;
                state_nxt      = S_REPLY;
              end else begin
                id_nxt      = next_id_r;
                next_id_nxt = (next_id_r == '1) ? IW'(1) : next_id_r + IW'(1);
                state_nxt   = S_SET_ADD;
              end
            end
            OP_CLEAR: begin
              if (cnt_r == '0) begin
                rep_kind_nxt   = KIND_CLEAR;
                rep_status_nxt = ST_NOT_FOUND;
                rep_id_nxt     = '0;
                state_nxt      = S_REPLY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_r;
                idx_nxt   = '0;
                found_nxt = 1'b0;
                state_nxt = S_CLR_WALK;
              end
            end
            OP_CLEAR_ALL: begin
              cnt_nxt        = '0;
              rep_kind_nxt   = KIND_CLEAR_ALL;
              rep_status_nxt = ST_OK;
              rep_id_nxt     = '0;
              state_nxt      = S_REPLY;
            end
            OP_TICK: begin
              now_nxt        = now_r + TW'(1);
              ram_re         = 1'b1;
              ram_raddr      = head_r;
              tick_n_nxt     = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_TICK_CHK;
            end
          endcase
        end
      end

      S_SET_ADD: begin
        dl_nxt = now_r + {{(TW-IW){1'b0}}, delay_r};
        if (cnt_r == '0) begin
          idx_nxt   = '0;
          state_nxt = S_SET_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_r, cnt_r - CW'(1));
          idx_nxt   = cnt_r - CW'(1);
          state_nxt = S_SET_WALK;
        end
      end

      // walk down from the tail, moving each later-or-equal entry up one slot
      S_SET_WALK: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, idx_r + CW'(1));
        if (ram_rdata.deadline >= dl_r) begin
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = S_SET_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = phys(head_r, idx_r - CW'(1));
            idx_nxt   = idx_r - CW'(1);
          end
        end else begin
          ram_wdata      = new_entry;
          cnt_nxt        = cnt_r + CW'(1);
          rep_kind_nxt   = KIND_SET;
          rep_status_nxt = ST_OK;
          rep_id_nxt     = id_r;
          state_nxt      = S_REPLY;
        end
      end

      S_SET_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = phys(head_r, idx_r);
        ram_wdata      = new_entry;
        cnt_nxt        = cnt_r + CW'(1);
        rep_kind_nxt   = KIND_SET;
        rep_status_nxt = ST_OK;
        rep_id_nxt     = id_r;
        state_nxt      = S_REPLY;
      end

      // search for the id; once found, every later entry moves down one slot
      S_CLR_WALK: begin
        if (found_r) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_r, idx_r - CW'(1));
          ram_wdata = ram_rdata;
        end
        if (idx_r + CW'(1) < cnt_r) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_r, idx_r + CW'(1));
          idx_nxt   = idx_r + CW'(1);
          found_nxt = found_r || match;
        end else begin
          if (found_r || match) begin
            cnt_nxt = cnt_r - CW'(1);
          end
          rep_kind_nxt   = KIND_CLEAR;
          rep_status_nxt = (found_r || match) ? ST_OK : ST_NOT_FOUND;
          rep_id_nxt     = '0;
          state_nxt      = S_REPLY;
        end
      end

      // head expiry: one expired entry is held back so that its last flag is known
      S_TICK_CHK: begin
        if (expire) begin
          if (!pend_valid_r || free) begin
            if (pend_valid_r) begin
              push      = 1'b1;
              push_beat = '{kind: KIND_EXPIRY, status: ST_OK, timer_id: pend_id_r,
                            tag: pend_tag_r, pending: PCW'(pend_cnt_r), last: 1'b0};
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = ram_rdata.id;
            pend_tag_nxt   = ram_rdata.tag;
            pend_cnt_nxt   = cnt_r - CW'(1);
            cnt_nxt        = cnt_r - CW'(1);
            head_nxt       = phys(head_r, CW'(1));
            tick_n_nxt     = tick_n_r + TNW'(1);
            ram_re         = 1'b1;
            ram_raddr      = phys(head_r, CW'(1));
          end
        end else if (free) begin
          push = 1'b1;
          if (pend_valid_r) begin
            push_beat = '{kind: KIND_EXPIRY, status: ST_OK, timer_id: pend_id_r,
                          tag: pend_tag_r, pending: PCW'(pend_cnt_r), last: 1'b1};
          end else begin
            push_beat = '{kind: KIND_TICK_IDLE, status: ST_OK, timer_id: '0,
                          tag: '0, pending: PCW'(cnt_r), last: 1'b1};
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      S_REPLY: begin
        if (free) begin
          push      = 1'b1;
          push_beat = '{kind: rep_kind_r, status: rep_status_r, timer_id: rep_id_r,
                        tag: '0, pending: PCW'(cnt_r), last: 1'b1};
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      now_r        <= '0;
      cnt_r        <= '0;
      head_r       <= '0;
      next_id_r    <= IW'(1);
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      cnt_r        <= cnt_nxt;
      head_r       <= head_nxt;
      next_id_r    <= next_id_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    delay_r      <= delay_nxt;
    tag_r        <= tag_nxt;
    target_r     <= target_nxt;
    dl_r         <= dl_nxt;
    id_r         <= id_nxt;
    rep_kind_r   <= rep_kind_nxt;
    rep_status_r <= rep_status_nxt;
    rep_id_r     <= rep_id_nxt;
    tick_n_r     <= tick_n_nxt;
    pend_id_r    <= pend_id_nxt;
    pend_tag_r   <= pend_tag_nxt;
    pend_cnt_r   <= pend_cnt_nxt;
  end

  sdtq_ram #(
    .WIDTH ($bits(sdtq_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sdtq_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_beat (push_beat),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .beat      (beat)
  );

  assign out_result_kind   = beat.kind;
  assign out_status        = beat.status;
  assign out_timer_id      = beat.timer_id;
  assign out_expired_tag   = beat.tag;
  assign out_pending_count = beat.pending;
  assign out_last_result   = beat.last;

  // occupancy never exceeds the queue depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above queue depth");

  // id zero is never handed out
  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != '0)
    else $error("next timer id is zero");

  // clear-all leaves an empty queue
  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_opcode == OP_CLEAR_ALL) |=> cnt_r == '0)
    else $error("queue not empty after clear-all");

  // memory is only written by the set walk, set put and clear walk states
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SET_WALK) || (state_r == S_SET_PUT)
               || (state_r == S_CLR_WALK))
    else $error("entry write outside a walk");

  // an expiry beat always comes from a held-back expired entry
  a_expiry_src: assert property (@(posedge clk) disable iff (!rst_n)
    push && (push_beat.kind == KIND_EXPIRY) |-> (state_r == S_TICK_CHK) && pend_valid_r
                                                && (tick_n_r != '0))
    else $error("expiry beat without a pending entry");

endmodule
